### rtl/core/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

    // Sizing of the request fields and the row buffers
    localparam int MAX_DICE   = 32;
    localparam int MAX_FACES  = 32;
    localparam int MAX_TARGET = 1024;
    localparam int ROW_DEPTH  = MAX_TARGET + 1;

    localparam int DICE_W  = 6;
    localparam int FACE_W  = 6;
    localparam int SUM_W   = 11;
    localparam int WAYS_W  = 30;

    localparam logic [WAYS_W-1:0] PRIME_MOD = 30'd1000000007;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ZERO,
        ST_SUM,
        ST_WRITE,
        ST_DIE_END,
        ST_FETCH,
        ST_LATCH
    } dsc_state_t;

    // Add two residues below the prime and reduce once
    function automatic logic [WAYS_W-1:0] add_mod(input logic [WAYS_W-1:0] a,
                                                   input logic [WAYS_W-1:0] b);
        logic [WAYS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME_MOD}) begin
            s = s - {1'b0, PRIME_MOD};
        end
        return s[WAYS_W-1:0];
    endfunction

endpackage

### rtl/core/dice_sum_count_mod_prime_unit.sv
`timescale 1ns / 1ps

// One shared modular adder takes one face term per cycle while a row entry is summed.
// Throughput: one request at a time; a new beat is taken once the result is latched.
// Out-of-range requests go straight to the latch state and return zero. A clearing
// pass first rewrites entries 0..target of the previous row buffer on each request.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid.
module dice_sum_count_mod_prime_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] dice_count, [11:6] face_count, [22:12] target_sum, [23] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [29:0] ways_count, [31:30] zero
    output logic [31:0] m_tdata
);
    import dsc_pkg::*;

    dsc_state_t state_reg, state_next;

    logic [DICE_W-1:0] dice_reg, dice_next;
    logic [FACE_W-1:0] faces_reg, faces_next;
    logic [SUM_W-1:0]  target_reg, target_next;
    logic [DICE_W-1:0] die_reg, die_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [FACE_W-1:0] face_reg, face_next;
    logic [WAYS_W-1:0] total_reg, total_next;
    logic              prev_bank_reg, prev_bank_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              res_zero_reg, res_zero_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [WAYS_W-1:0] m_data_reg, m_data_next;

    logic              s_accept;
    logic              in_range;
    logic              face_last;
    logic              out_free;
    logic [DICE_W-1:0] in_dice;
    logic [FACE_W-1:0] in_faces;
    logic [SUM_W-1:0]  in_target;

    // Row buffer ports
    logic              wr_en;
    logic              wr_bank;
    logic [SUM_W-1:0]  wr_addr;
    logic [WAYS_W-1:0] wr_data;
    logic [SUM_W-1:0]  rd_addr;
    logic [WAYS_W-1:0] rd_data0_reg;
    logic [WAYS_W-1:0] rd_data1_reg;
    logic [WAYS_W-1:0] rd_data;
    logic [WAYS_W-1:0] sum_term;

    logic [WAYS_W-1:0] row0_mem [ROW_DEPTH];
    logic [WAYS_W-1:0] row1_mem [ROW_DEPTH];

    assign in_dice   = s_tdata[5:0];
    assign in_faces  = s_tdata[11:6];
    assign in_target = s_tdata[22:12];
    assign in_range  = ({26'd0, in_dice} <= MAX_DICE) && ({26'd0, in_faces} <= MAX_FACES)
                       && ({21'd0, in_target} <= MAX_TARGET);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, m_data_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    assign face_last = (faces_reg == '0) || (face_reg == faces_reg)
                       || ({5'd0, face_reg} == sum_reg);
    assign rd_data   = prev_bank_reg ? rd_data1_reg : rd_data0_reg;
    assign sum_term  = rd_valid_reg ? add_mod(total_reg, rd_data) : total_reg;

    // Row buffers: one write and one registered read per cycle each
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_bank) begin
            row0_mem[wr_addr] <= wr_data;
        end
        rd_data0_reg <= row0_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_bank) begin
            row1_mem[wr_addr] <= wr_data;
        end
        rd_data1_reg <= row1_mem[rd_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = in_range ? ST_CLEAR : ST_LATCH;
                end
            end
            ST_CLEAR: begin
                if (sum_reg == target_reg) begin
                    state_next = (dice_reg == '0) ? ST_FETCH : ST_ZERO;
                end
            end
            ST_ZERO: begin
                state_next = (target_reg == '0) ? ST_DIE_END : ST_SUM;
            end
            ST_SUM: begin
                if (face_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = (sum_reg == target_reg) ? ST_DIE_END : ST_SUM;
            end
            ST_DIE_END: begin
                state_next = (die_reg == dice_reg) ? ST_FETCH : ST_ZERO;
            end
            ST_FETCH: begin
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and buffer control
    always_comb begin
        dice_next      = dice_reg;
        faces_next     = faces_reg;
        target_next    = target_reg;
        die_next       = die_reg;
        sum_next       = sum_reg;
        face_next      = face_reg;
        total_next     = total_reg;
        prev_bank_next = prev_bank_reg;
        rd_valid_next  = 1'b0;
        res_zero_next  = res_zero_reg;
        m_data_next    = m_data_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        wr_en          = 1'b0;
        wr_bank        = !prev_bank_reg;
        wr_addr        = sum_reg;
        wr_data        = '0;
        rd_addr        = target_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    dice_next     = in_dice;
                    faces_next    = in_faces;
                    target_next   = in_target;
                    res_zero_next = !in_range;
                    sum_next      = '0;
                    die_next      = {{(DICE_W-1){1'b0}}, 1'b1};
                end
            end
            ST_CLEAR: begin
                // Seed the previous row: one way to reach sum zero
                wr_en   = 1'b1;
                wr_bank = prev_bank_reg;
                wr_data = (sum_reg == '0) ? {{(WAYS_W-1){1'b0}}, 1'b1} : '0;
                sum_next = sum_reg + 1'b1;
            end
            ST_ZERO: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                sum_next   = {{(SUM_W-1){1'b0}}, 1'b1};
                face_next  = {{(FACE_W-1){1'b0}}, 1'b1};
                total_next = '0;
            end
            ST_SUM: begin
                // Issue one face term per cycle, fold the one read last cycle
                rd_addr       = sum_reg - {5'd0, face_reg};
                rd_valid_next = (faces_reg != '0);
                total_next    = sum_term;
                face_next     = face_reg + 1'b1;
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                wr_data    = sum_term;
                total_next = '0;
                sum_next   = sum_reg + 1'b1;
                face_next  = {{(FACE_W-1){1'b0}}, 1'b1};
            end
            ST_DIE_END: begin
                prev_bank_next = !prev_bank_reg;
                die_next       = die_reg + 1'b1;
            end
            ST_FETCH: begin
                rd_addr = target_reg;
            end
            ST_LATCH: begin
                // Hold the read address so the result word stays put while stalled
                rd_addr = target_reg;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_zero_reg ? '0 : rd_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            prev_bank_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            rd_valid_reg  <= rd_valid_next;
            prev_bank_reg <= prev_bank_next;
        end
        dice_reg     <= dice_next;
        faces_reg    <= faces_next;
        target_reg   <= target_next;
        die_reg      <= die_next;
        sum_reg      <= sum_next;
        face_reg     <= face_next;
        total_reg    <= total_next;
        res_zero_reg <= res_zero_next;
        m_data_reg   <= m_data_next;
    end

    // A face term never reaches below sum zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> ({5'd0, face_reg} <= sum_reg))
        else $error("face index beyond current sum");

    // A row entry is written only after its face terms were issued
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> ($past(state_reg) == ST_SUM))
        else $error("row write without face pass");

    // The die counter stays within the requested dice while working
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM || state_reg == ST_WRITE || state_reg == ST_ZERO)
        |-> (die_reg <= dice_reg && die_reg != '0))
        else $error("die counter out of range");

    // An accepted beat always starts work
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != ST_IDLE))
        else $error("accepted beat dropped");

    // The running total stays a residue of the prime
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (total_reg < PRIME_MOD))
        else $error("running total not reduced");

endmodule
